/* rtl/core/tshsm_pkg.sv */
// ----------------------------------------------------------------------------
// tshsm_pkg
// Shared constants for the time-source holdover state machine: lock state
// codes, status flag bits, thresholds and configuration register indexes.
// ----------------------------------------------------------------------------
package tshsm_pkg;

  // Default widths for the top-level parameters
  localparam int PERIOD_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_JITTER_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 1'd1;

  localparam int JITTER_THR_W = 32;
  localparam int HOLD_LIMIT_W = 16;

  localparam logic [JITTER_THR_W-1:0] JITTER_THR_RST = 32'd1250;
  localparam logic [HOLD_LIMIT_W-1:0] HOLD_LIMIT_RST = 16'd600;

  // Lock state codes
  localparam logic [1:0] ST_LOST   = 2'd0;
  localparam logic [1:0] ST_FOLLOW = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  // Status flag bits
  localparam logic [2:0] FLAG_SRC    = 3'b001;
  localparam logic [2:0] FLAG_FOLLOW = 3'b010;
  localparam logic [2:0] FLAG_KEEP   = 3'b100;
  localparam logic [2:0] FLAG_NONE   = 3'b000;

  localparam int FLAG_SRC_BIT    = 0;
  localparam int FLAG_FOLLOW_BIT = 1;
  localparam int FLAG_KEEP_BIT   = 2;

  // Holdover submodes
  localparam logic KEEP_NO_SRC  = 1'b0;
  localparam logic KEEP_WITH_SRC = 1'b1;

  // Thresholds
  localparam int         STABLE_NEEDED   = 9;
  localparam logic [7:0] EDGE_ERR_LIMIT  = 8'd4;
  localparam logic [3:0] QUALITY_UNKNOWN = 4'hF;
  localparam logic [7:0] MIN_FRAMES      = 8'd2;

endpackage

/* rtl/core/timesync_holdover_state_machine.sv */
// ----------------------------------------------------------------------------
// timesync_holdover_state_machine
// Per-second jitter check and lost / follow / holdover state machine for an
// external time source, with quality forcing and status flags.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle when the result side keeps up: an item
// transfers into the input register, and while it is held there its jitter
// check and state update run in one pass of compare-and-select logic; the
// result is loaded into the output register when the item advances. The
// output register decouples the two sides, so a new item is accepted while
// a finished result still waits to be taken; the input stalls only
// when both the input and the output register are full and the result
// side is stalling. Configuration writes are to be made only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module timesync_holdover_state_machine #(
  parameter int PERIOD_WIDTH = tshsm_pkg::PERIOD_WIDTH_DEF,
  parameter int COUNT_WIDTH  = tshsm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  // Configuration write port
  input  logic                             cfg_wr_en,
  input  logic [tshsm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tshsm_pkg::CFG_DATA_W-1:0] cfg_data,

  // Input channel
  input  logic                             in_vld,
  output logic                             in_stall,
  input  logic                             in_source_alive,
  input  logic [PERIOD_WIDTH-1:0]          in_pulse_period,
  input  logic [7:0]                       in_consecutive_frames,
  input  logic [7:0]                       in_edge_error_count,
  input  logic [3:0]                       in_source_quality,

  // Result channel
  output logic                             out_vld,
  input  logic                             out_stall,
  output logic [1:0]                       out_sync_state,
  output logic                             out_holdover_mode,
  output logic                             out_flag_source_ok,
  output logic                             out_flag_follow,
  output logic                             out_flag_keep,
  output logic [3:0]                       out_time_quality,
  output logic                             out_ever_locked,
  output logic [COUNT_WIDTH-1:0]           out_stable_run,
  output logic                             out_jitter_event
);

  // Comparison widths wide enough for both operands
  localparam int THR_W  = tshsm_pkg::JITTER_THR_W;
  localparam int LIM_W  = tshsm_pkg::HOLD_LIMIT_W;
  localparam int PCMP_W = (PERIOD_WIDTH > THR_W) ? PERIOD_WIDTH : THR_W;
  localparam int HCMP_W = (COUNT_WIDTH > LIM_W) ? COUNT_WIDTH : LIM_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration registers
  logic [THR_W-1:0] jitter_thr_r;
  logic [LIM_W-1:0] hold_limit_r;

  // Input register
  logic                    in_vld_r;
  logic                    alive_r;
  logic [PERIOD_WIDTH-1:0] period_r;
  logic [7:0]              frames_r;
  logic [7:0]              edge_err_r;
  logic [3:0]              src_q_r;

  // Machine state
  logic [1:0]              lock_state_r, lock_state_nxt;
  logic                    keep_sub_r, keep_sub_nxt;
  logic [COUNT_WIDTH-1:0]  hold_secs_r, hold_secs_nxt;
  logic [COUNT_WIDTH-1:0]  stable_secs_r, stable_secs_nxt;
  logic [COUNT_WIDTH-1:0]  jitter_secs_r, jitter_secs_nxt;
  logic [PERIOD_WIDTH-1:0] prev_period_r;
  logic [2:0]              flags_r, flags_nxt;
  logic [3:0]              quality_r, quality_nxt;
  logic                    locked_once_r, locked_once_nxt;
  logic                    jitter_ev;

  logic advance;

  // Item moves from the input register to the output register
  assign advance  = in_vld_r && (!out_vld || !out_stall);
  assign in_stall = in_vld_r && !advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jitter_thr_r <= tshsm_pkg::JITTER_THR_RST;
      hold_limit_r <= tshsm_pkg::HOLD_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        tshsm_pkg::REG_JITTER_THR: jitter_thr_r <= cfg_data[THR_W-1:0];
        tshsm_pkg::REG_HOLD_LIMIT: hold_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_vld && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && !in_stall) begin
      alive_r    <= in_source_alive;
      period_r   <= in_pulse_period;
      frames_r   <= in_consecutive_frames;
      edge_err_r <= in_edge_error_count;
      src_q_r    <= in_source_quality;
    end
  end

  // Jitter check, holdover count and lock state machine
  always_comb begin
    logic [PERIOD_WIDTH-1:0] diff;
    logic                    over_limit;

    lock_state_nxt  = lock_state_r;
    keep_sub_nxt    = keep_sub_r;
    hold_secs_nxt   = hold_secs_r;
    stable_secs_nxt = stable_secs_r;
    jitter_secs_nxt = jitter_secs_r;
    flags_nxt       = flags_r;
    quality_nxt     = quality_r;
    locked_once_nxt = locked_once_r;
    jitter_ev       = 1'b0;

    // period jitter, skipped on a short frame run
    diff = (period_r > prev_period_r) ? (period_r - prev_period_r)
                                      : (prev_period_r - period_r);
    if (frames_r > tshsm_pkg::MIN_FRAMES) begin
      if (PCMP_W'(diff) > PCMP_W'(jitter_thr_r)) begin
        jitter_ev       = 1'b1;
        jitter_secs_nxt = (jitter_secs_r == CNT_MAX) ? CNT_MAX
                                                     : jitter_secs_r + 1'b1;
        stable_secs_nxt = '0;
      end else begin
        stable_secs_nxt = (stable_secs_r == CNT_MAX) ? CNT_MAX
                                                     : stable_secs_r + 1'b1;
        jitter_secs_nxt = '0;
      end
    end

    // holdover seconds count outside follow
    if (lock_state_r != tshsm_pkg::ST_FOLLOW) begin
      hold_secs_nxt = (hold_secs_r == CNT_MAX) ? CNT_MAX : hold_secs_r + 1'b1;
    end
    over_limit = HCMP_W'(hold_secs_nxt) > HCMP_W'(hold_limit_r);

    case (lock_state_r)
      tshsm_pkg::ST_LOST: begin
        if ((stable_secs_nxt >= COUNT_WIDTH'(tshsm_pkg::STABLE_NEEDED)) && alive_r) begin
          lock_state_nxt  = tshsm_pkg::ST_FOLLOW;
          locked_once_nxt = 1'b1;
          flags_nxt       = tshsm_pkg::FLAG_SRC | tshsm_pkg::FLAG_FOLLOW;
          quality_nxt     = src_q_r;
        end else begin
          flags_nxt = alive_r ? tshsm_pkg::FLAG_SRC : tshsm_pkg::FLAG_NONE;
        end
      end
      tshsm_pkg::ST_FOLLOW: begin
        hold_secs_nxt = '0;
        if (!alive_r) begin
          lock_state_nxt = tshsm_pkg::ST_HOLD;
          keep_sub_nxt   = tshsm_pkg::KEEP_NO_SRC;
          flags_nxt      = tshsm_pkg::FLAG_KEEP;
        end else begin
          quality_nxt = src_q_r;
        end
      end
      tshsm_pkg::ST_HOLD: begin
        if (alive_r && (edge_err_r == 8'd0)) begin
          // clean source back: resume following
          lock_state_nxt = tshsm_pkg::ST_FOLLOW;
          flags_nxt      = tshsm_pkg::FLAG_SRC | tshsm_pkg::FLAG_FOLLOW;
          quality_nxt    = src_q_r;
        end else begin
          if (over_limit) begin
            quality_nxt = tshsm_pkg::QUALITY_UNKNOWN;
          end
          if (keep_sub_r == tshsm_pkg::KEEP_NO_SRC) begin
            flags_nxt = tshsm_pkg::FLAG_KEEP;
            if (!alive_r) begin
              if (over_limit) begin
                lock_state_nxt  = tshsm_pkg::ST_LOST;
                flags_nxt       = tshsm_pkg::FLAG_NONE;
                stable_secs_nxt = '0;
              end
            end else begin
              keep_sub_nxt = tshsm_pkg::KEEP_WITH_SRC;
            end
          end else begin
            flags_nxt = tshsm_pkg::FLAG_SRC | tshsm_pkg::FLAG_KEEP;
            if (!alive_r) begin
              keep_sub_nxt = tshsm_pkg::KEEP_NO_SRC;
              flags_nxt    = tshsm_pkg::FLAG_KEEP;
            end else if (edge_err_r >= tshsm_pkg::EDGE_ERR_LIMIT) begin
              lock_state_nxt  = tshsm_pkg::ST_LOST;
              flags_nxt       = tshsm_pkg::FLAG_SRC;
              stable_secs_nxt = '0;
            end
          end
        end
      end
      default: begin
        lock_state_nxt = tshsm_pkg::ST_LOST;
        flags_nxt      = tshsm_pkg::FLAG_NONE;
        quality_nxt    = tshsm_pkg::QUALITY_UNKNOWN;
      end
    endcase
  end

  // State update on each transfer to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_state_r  <= tshsm_pkg::ST_LOST;
      keep_sub_r    <= tshsm_pkg::KEEP_NO_SRC;
      hold_secs_r   <= '0;
      stable_secs_r <= '0;
      jitter_secs_r <= '0;
      prev_period_r <= '0;
      flags_r       <= tshsm_pkg::FLAG_NONE;
      quality_r     <= tshsm_pkg::QUALITY_UNKNOWN;
      locked_once_r <= 1'b0;
    end else if (advance) begin
      lock_state_r  <= lock_state_nxt;
      keep_sub_r    <= keep_sub_nxt;
      hold_secs_r   <= hold_secs_nxt;
      stable_secs_r <= stable_secs_nxt;
      jitter_secs_r <= jitter_secs_nxt;
      prev_period_r <= period_r;
      flags_r       <= flags_nxt;
      quality_r     <= quality_nxt;
      locked_once_r <= locked_once_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (!out_stall) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sync_state     <= lock_state_nxt;
      out_holdover_mode  <= (lock_state_nxt == tshsm_pkg::ST_HOLD) ? keep_sub_nxt : 1'b0;
      out_flag_source_ok <= flags_nxt[tshsm_pkg::FLAG_SRC_BIT];
      out_flag_follow    <= flags_nxt[tshsm_pkg::FLAG_FOLLOW_BIT];
      out_flag_keep      <= flags_nxt[tshsm_pkg::FLAG_KEEP_BIT];
      out_time_quality   <= quality_nxt;
      out_ever_locked    <= locked_once_nxt;
      out_stable_run     <= stable_secs_nxt;
      out_jitter_event   <= jitter_ev;
    end
  end

endmodule
